[sv/bhpq_pkg.sv]
// Package for the binary heap priority queue: payload structs, status codes,
// controller/datapath command and status structs. No dependencies.
package bhpq_pkg;

  localparam int CAPACITY_DEF  = 256;
  localparam int KEY_WIDTH_DEF = 32;
  localparam int COUNT_W       = $clog2(CAPACITY_DEF + 1);

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  typedef struct packed {
    logic                     action;
    logic [KEY_WIDTH_DEF-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [KEY_WIDTH_DEF-1:0] top_key;
    logic                     top_valid;
    logic [COUNT_W-1:0]       count;
  } out_item_t;

  // Datapath commands issued by the controller.
  typedef struct packed {
    logic load_in;     // capture input item
    logic push_start;  // count++, write key at new last slot, pos = count+1
    logic pop_start;   // read last slot
    logic pop_move;    // write last to root, count--, pos = 1
    logic rd_node;     // read parent of pos (up mode) or left child
    logic rd_kid;      // read left child of pos
    logic rd_kid2;     // read right child
    logic do_swap;     // write other at pos, pos = target
    logic wr_cur;      // sift done: moving key lands at pos
    logic up_mode;     // target is parent (sift up) vs best child
    logic rd_root;     // read root for result
    logic set_result;  // load output register
    logic res_full;
    logic res_empty;
  } dp_cmd_t;

  typedef struct packed {
    logic act_pop;
    logic full;
    logic empty;
    logic at_root;     // pos == 1
    logic up_swap;     // parent ranks after node
    logic dn_swap;     // a child ranks before node
    logic small_after; // count <= 1 after pop
  } dp_stat_t;

endpackage

[sv/bhpq_ram.sv]
// Generic single-port RAM, one write or read per cycle, registered read.
// No dependencies.
module bhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

[sv/bhpq_dp.sv]
// Datapath: heap RAM, count, position, key registers, compare logic.
// Depends on bhpq_pkg and bhpq_ram.
module bhpq_dp #(
  parameter int CAPACITY  = bhpq_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH = bhpq_pkg::KEY_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                largest_first,
  input  bhpq_pkg::in_item_t  in_item,
  input  bhpq_pkg::dp_cmd_t   cmd,
  output bhpq_pkg::dp_stat_t  stat,
  output bhpq_pkg::out_item_t result
);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int AW  = $clog2(CAPACITY);
  localparam int OKW = bhpq_pkg::KEY_WIDTH_DEF;
  localparam int OCW = bhpq_pkg::COUNT_W;
  localparam int TAG_PAR = 0, TAG_LK = 1, TAG_RK = 2;

  // Slot i (one-based) lives at RAM address i-1.
  logic [CW-1:0]        count;
  logic [CW-1:0]        pos;
  logic                 action;
  logic [KEY_WIDTH-1:0] cur;    // key being sifted
  logic [KEY_WIDTH-1:0] other;  // parent or best child key
  logic [CW:0]          tgt;    // parent or best child slot
  logic                 kid_ok; // a child already captured into other
  logic [2:0]           rd_tag; // pending read kind, one-hot
  logic                 we;
  logic [AW-1:0]        addr;
  logic [KEY_WIDTH-1:0] wdata, rdata;
  logic [CW:0]          left, right;

  assign left  = {pos, 1'b0};
  assign right = left + (CW+1)'(1);

  function automatic logic ranks_before(input logic lf, input logic [KEY_WIDTH-1:0] a,
                                        input logic [KEY_WIDTH-1:0] b);
    ranks_before = lf ? (a > b) : (a < b);
  endfunction

  bhpq_ram #(.WIDTH(KEY_WIDTH), .DEPTH(CAPACITY)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  always_comb begin
    we    = 1'b0;
    addr  = '0;
    wdata = cur;
    if (cmd.push_start) begin
      we   = 1'b1;
      addr = AW'(count);
    end else if (cmd.pop_start) begin
      addr = AW'(count - CW'(1));
    end else if (cmd.pop_move) begin
      we = 1'b1; addr = '0; wdata = rdata;
    end else if (cmd.rd_node) begin
      addr = cmd.up_mode ? AW'((pos >> 1) - CW'(1)) : AW'(left - (CW+1)'(1));
    end else if (cmd.rd_kid) begin
      addr = AW'(left - (CW+1)'(1));
    end else if (cmd.rd_kid2) begin
      addr = AW'(right - (CW+1)'(1));
    end else if (cmd.do_swap) begin
      we = 1'b1; addr = AW'(pos - CW'(1)); wdata = other;
    end else if (cmd.wr_cur) begin
      we = 1'b1; addr = AW'(pos - CW'(1)); wdata = cur;
    end else if (cmd.rd_root) begin
      addr = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      rd_tag <= '0;
      kid_ok <= 1'b0;
    end else begin
      rd_tag <= {cmd.rd_kid2, cmd.rd_kid, cmd.rd_node};
      if (cmd.load_in) begin
        action <= in_item.action;
        cur    <= KEY_WIDTH'(in_item.key);
      end
      if (cmd.push_start) begin
        count <= count + CW'(1);
        pos   <= count + CW'(1);
      end
      if (cmd.pop_move) begin
        count  <= count - CW'(1);
        pos    <= CW'(1);
        cur    <= rdata;
        kid_ok <= 1'b0;
      end
      if (cmd.rd_node) begin
        tgt <= (CW+1)'(pos >> 1);
      end
      if (cmd.rd_kid) begin
        kid_ok <= 1'b0;
      end
      // Capture read data in the cycle after the address.
      if (rd_tag[TAG_PAR]) begin
        other <= rdata;
      end
      if (rd_tag[TAG_LK]) begin
        if (left <= (CW+1)'(count) && ranks_before(largest_first, rdata, cur)) begin
          other <= rdata; tgt <= left; kid_ok <= 1'b1;
        end
      end
      if (rd_tag[TAG_RK]) begin
        if (right <= (CW+1)'(count) &&
            ranks_before(largest_first, rdata, kid_ok ? other : cur)) begin
          other <= rdata; tgt <= right; kid_ok <= 1'b1;
        end
      end
      if (cmd.do_swap) begin
        pos    <= CW'(tgt);
        kid_ok <= 1'b0;
      end
    end
  end

  // The moving key stays in cur during a sift; wr_cur places it at the end.
  assign stat.act_pop     = action;
  assign stat.full        = (count == CW'(CAPACITY));
  assign stat.empty       = (count == '0);
  assign stat.at_root     = (pos == CW'(1));
  assign stat.up_swap     = ranks_before(largest_first, cur, other);
  assign stat.dn_swap     = kid_ok;
  assign stat.small_after = (count <= CW'(1));

  always_ff @(posedge clk) begin
    if (cmd.set_result) begin
      result.status    <= cmd.res_full ? bhpq_pkg::ST_FULL :
                          cmd.res_empty ? bhpq_pkg::ST_EMPTY : bhpq_pkg::ST_DONE;
      result.top_key   <= (count == '0) ? '0 : OKW'(rdata);
      result.top_valid <= (count != '0);
      result.count     <= OCW'(count);
    end
  end
endmodule

[sv/bhpq_ctrl.sv]
// Controller state machine sequencing push sift-up and pop sift-down.
// Depends on bhpq_pkg.
module bhpq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  bhpq_pkg::dp_stat_t stat,
  output bhpq_pkg::dp_cmd_t  cmd
);
  localparam logic [3:0] S_IDLE = 4'd0, S_DEC = 4'd1, S_UPRD = 4'd2, S_UPWT = 4'd3,
                         S_UPCMP = 4'd4, S_POPRD = 4'd5, S_POPMV = 4'd6, S_LK = 4'd7,
                         S_RK = 4'd8, S_DNWT = 4'd9, S_DNCMP = 4'd10, S_FIN = 4'd11,
                         S_ROOT = 4'd12, S_RES = 4'd13, S_ROOTW = 4'd14;
  logic [3:0] state, state_next;
  logic       res_full, res_empty, res_full_next, res_empty_next;
  logic       out_valid_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    res_full_next = res_full;
    res_empty_next = res_empty;
    out_valid_next = out_valid && out_stall;
    cmd.res_full = res_full;
    cmd.res_empty = res_empty;
    case (state)
      S_IDLE: if (in_valid && !in_stall) begin
        cmd.load_in = 1'b1; state_next = S_DEC;
      end
      S_DEC: begin
        res_full_next = 1'b0; res_empty_next = 1'b0;
        if (stat.act_pop == bhpq_pkg::ACT_PUSH) begin
          if (stat.full) begin res_full_next = 1'b1; state_next = S_ROOT; end
          else begin cmd.push_start = 1'b1; state_next = S_UPRD; end
        end else begin
          if (stat.empty) begin res_empty_next = 1'b1; state_next = S_ROOT; end
          else begin cmd.pop_start = 1'b1; state_next = S_POPRD; end
        end
      end
      S_UPRD: begin
        if (stat.at_root) state_next = S_FIN;
        else begin cmd.rd_node = 1'b1; cmd.up_mode = 1'b1; state_next = S_UPWT; end
      end
      S_UPWT: state_next = S_UPCMP;
      S_UPCMP: begin
        if (stat.up_swap) begin
          cmd.do_swap = 1'b1; cmd.up_mode = 1'b1; state_next = S_UPRD;
        end else state_next = S_FIN;
      end
      // Last slot is on the read port now.
      S_POPRD: begin cmd.pop_move = 1'b1; state_next = S_POPMV; end
      S_POPMV: begin
        if (stat.small_after) state_next = S_FIN;
        else state_next = S_LK;
      end
      S_LK: begin cmd.rd_kid = 1'b1; state_next = S_RK; end
      S_RK: begin cmd.rd_kid2 = 1'b1; state_next = S_DNWT; end
      S_DNWT: state_next = S_DNCMP;
      S_DNCMP: begin
        if (stat.dn_swap) begin cmd.do_swap = 1'b1; state_next = S_LK; end
        else state_next = S_FIN;
      end
      S_FIN: begin cmd.wr_cur = 1'b1; state_next = S_ROOT; end
      S_ROOT: begin cmd.rd_root = 1'b1; state_next = S_ROOTW; end
      S_ROOTW: state_next = S_RES;
      S_RES: if (!(out_valid && out_stall)) begin
        cmd.set_result = 1'b1; out_valid_next = 1'b1; state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; out_valid <= 1'b0; res_full <= 1'b0; res_empty <= 1'b0;
    end else begin
      state <= state_next; out_valid <= out_valid_next;
      res_full <= res_full_next; res_empty <= res_empty_next;
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("accept while busy");
  a_res_from_res: assert property (@(posedge clk) disable iff (rst)
    cmd.set_result |=> out_valid) else $error("result not shown");
  a_one_flag: assert property (@(posedge clk) disable iff (rst)
    !(res_full && res_empty)) else $error("both refusal flags");
`endif
endmodule

[sv/binary_heap_priority_queue.sv]
// Top level of the binary heap priority queue.
// Depends on bhpq_pkg, bhpq_ctrl, bhpq_dp.
//
//  channel | signals                      | direction
//  in      | in_valid, in_stall, in_data  | item in (action, key)
//  out     | out_valid, out_stall, out_data | result out
//  cfg     | cfg_we, cfg_data             | largest_first register
//
// Each item is finished before the next is accepted: a refused push or pop only reads
// the root; a push writes the key at the new last slot and sifts it up; a pop moves
// the last entry to the root and sifts it down, reading both children per level.
// The single-port RAM serves one access per cycle.
// Synchronous reset empties the heap; RAM contents are not cleared.
// Input stalls while an item is in flight; a stalled result holds the controller.
module binary_heap_priority_queue #(
  parameter int CAPACITY  = bhpq_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH = bhpq_pkg::KEY_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  bhpq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bhpq_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_data
);
  logic               largest_first;
  bhpq_pkg::dp_cmd_t  cmd;
  bhpq_pkg::dp_stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) largest_first <= 1'b0;
    else if (cfg_we) largest_first <= cfg_data;
  end

  bhpq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .stat(stat), .cmd(cmd)
  );

  bhpq_dp #(.CAPACITY(CAPACITY), .KEY_WIDTH(KEY_WIDTH)) u_dp (
    .clk(clk), .rst(rst), .largest_first(largest_first), .in_item(in_data),
    .cmd(cmd), .stat(stat), .result(out_data)
  );
endmodule
